@@ rtl/hprc_pkg.sv @@
package hprc_pkg;

  // Table geometry
  localparam int TABLE_DEPTH = 1024;
  localparam int COUNT_BITS  = 16;
  localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int VAL_W       = 10;
  localparam int CNT_OUT_W   = 16;
  localparam int TOP_W       = (ADDR_W > VAL_W) ? ADDR_W : VAL_W;

  // Item actions
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_VALUE     = 3'd1,
    ST_FULL      = 3'd2,
    ST_INTERVAL  = 3'd3,
    ST_NOT_BUILT = 3'd4
  } status_e;

  typedef struct packed {
    logic             action;
    logic [VAL_W-1:0] value;
    logic             last;
    logic [VAL_W-1:0] range_low;
    logic [VAL_W-1:0] range_high;
  } hprc_in_t;

  typedef struct packed {
    status_e              status;
    logic [CNT_OUT_W-1:0] count;
  } hprc_out_t;

endpackage

@@ rtl/histogram_prefix_range_count_core.sv @@
// Channel   | Ports                    | Handshake
// ----------+--------------------------+----------------------------------------
// command   | start_i, cmd_i, busy_o   | word taken at edge with start_i & !busy_o
// result    | done_o, result_o         | one-cycle strobe, no back-pressure
// config    | cfg_we_i, cfg_wdata_i    | value_range written at edge with cfg_we_i
//
// A counted load reads its table entry and writes back the bumped count; a rejected
// load skips the table. The first load of a new set first clears all TABLE_DEPTH
// table entries. A load marked last adds a prefix pass up to the clamped range top
// (one table entry per cycle through the single read port and single write port).
// A good query makes two table reads; a rejected query is answered from idle.
// Reset clears control state only; the table is cleared when a set opens.
// busy_o stays high while a word is in work; results cannot be stalled.
module histogram_prefix_range_count_core (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  hprc_pkg::hprc_in_t       cmd_i,
  output logic                     busy_o,
  output logic                     done_o,
  output hprc_pkg::hprc_out_t      result_o,
  input  logic                     cfg_we_i,
  input  logic [hprc_pkg::VAL_W-1:0] cfg_wdata_i
);
  import hprc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLR,
    S_LD,
    S_LD_WR,
    S_PFX,
    S_Q_LO,
    S_Q_END
  } state_e;

  state_e                state_q, state_d;
  hprc_in_t              item_q, item_d;
  logic [VAL_W-1:0]      vrange_q, vrange_d;
  logic [COUNT_BITS-1:0] loaded_q, loaded_d;
  logic                  built_q, built_d;
  logic                  open_q, open_d;
  logic [ADDR_W:0]       k_q, k_d;
  logic                  pv_q, pv_d;
  logic [ADDR_W-1:0]     pa_q, pa_d;
  logic [COUNT_BITS-1:0] run_q, run_d;
  logic [COUNT_BITS-1:0] hi_q, hi_d;
  logic                  done_q, done_d;
  hprc_out_t             res_q, res_d;

  logic [COUNT_BITS-1:0] mem [TABLE_DEPTH];
  logic [COUNT_BITS-1:0] rdata_q;
  logic                  re, we;
  logic [ADDR_W-1:0]     ra, wa;
  logic [COUNT_BITS-1:0] wd;

  logic                  accept;
  logic [TOP_W-1:0]      top;
  logic [COUNT_BITS-1:0] sum;
  logic [COUNT_BITS-1:0] diff;

  assign accept = start_i && (state_q == S_IDLE);
  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;
  assign result_o = res_q;

  // Clamp the counted range to the table
  assign top = (TOP_W'(vrange_q) < TOP_W'(TABLE_DEPTH - 1)) ? TOP_W'(vrange_q)
                                                            : TOP_W'(TABLE_DEPTH - 1);

  assign sum  = run_q + rdata_q;
  assign diff = hi_q - ((item_q.range_low != '0) ? rdata_q : '0);

  // Sequencer
  always_comb begin
    state_d  = state_q;
    item_d   = item_q;
    vrange_d = vrange_q;
    loaded_d = loaded_q;
    built_d  = built_q;
    open_d   = open_q;
    k_d      = k_q;
    pv_d     = pv_q;
    pa_d     = pa_q;
    run_d    = run_q;
    hi_d     = hi_q;
    done_d   = 1'b0;
    res_d    = res_q;
    re       = 1'b0;
    ra       = '0;
    we       = 1'b0;
    wa       = '0;
    wd       = '0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          item_d = cmd_i;
          if (cmd_i.action == ACT_LOAD) begin
            k_d     = '0;
            state_d = open_q ? S_LD : S_CLR;
          end else if (!built_q) begin
            done_d = 1'b1;
            res_d  = '{status: ST_NOT_BUILT, count: '0};
          end else if ((cmd_i.range_low > cmd_i.range_high)
                       || (TOP_W'(cmd_i.range_high) > top)) begin
            done_d = 1'b1;
            res_d  = '{status: ST_INTERVAL, count: '0};
          end else begin
            re      = 1'b1;
            ra      = ADDR_W'(cmd_i.range_high);
            state_d = S_Q_LO;
          end
        end
      end

      // Zero the table when a new set opens
      S_CLR: begin
        we = 1'b1;
        wa = k_q[ADDR_W-1:0];
        wd = '0;
        k_d = k_q + 1'b1;
        if (k_q[ADDR_W-1:0] == ADDR_W'(TABLE_DEPTH - 1)) begin
          loaded_d = '0;
          built_d  = 1'b0;
          open_d   = 1'b1;
          state_d  = S_LD;
        end
      end

      S_LD: begin
        if (TOP_W'(item_q.value) > top || (&loaded_q)) begin
          res_d = '{status: (TOP_W'(item_q.value) > top) ? ST_VALUE : ST_FULL,
                    count: '0};
          if (item_q.last) begin
            k_d = '0; pv_d = 1'b0; run_d = '0;
            state_d = S_PFX;
          end else begin
            done_d  = 1'b1;
            state_d = S_IDLE;
          end
        end else begin
          re       = 1'b1;
          ra       = ADDR_W'(item_q.value);
          loaded_d = loaded_q + 1'b1;
          state_d  = S_LD_WR;
        end
      end

      // Write back the bumped count
      S_LD_WR: begin
        we    = 1'b1;
        wa    = ADDR_W'(item_q.value);
        wd    = rdata_q + 1'b1;
        res_d = '{status: ST_OK, count: '0};
        if (item_q.last) begin
          k_d = '0; pv_d = 1'b0; run_d = '0;
          state_d = S_PFX;
        end else begin
          done_d  = 1'b1;
          state_d = S_IDLE;
        end
      end

      // Read entry k while writing the running total of entry k-1
      S_PFX: begin
        if (pv_q) begin
          we    = 1'b1;
          wa    = pa_q;
          wd    = sum;
          run_d = sum;
        end
        if (k_q <= (ADDR_W + 1)'(top)) begin
          re   = 1'b1;
          ra   = k_q[ADDR_W-1:0];
          pv_d = 1'b1;
          pa_d = k_q[ADDR_W-1:0];
          k_d  = k_q + 1'b1;
        end else begin
          pv_d = 1'b0;
          if (!pv_q) begin
            built_d = 1'b1;
            open_d  = 1'b0;
            done_d  = 1'b1;
            state_d = S_IDLE;
          end
        end
      end

      // Hold the upper prefix and fetch the one below the interval
      S_Q_LO: begin
        hi_d    = rdata_q;
        re      = 1'b1;
        ra      = ADDR_W'(item_q.range_low - 1'b1);
        state_d = S_Q_END;
      end

      S_Q_END: begin
        done_d  = 1'b1;
        res_d   = '{status: ST_OK, count: CNT_OUT_W'(diff)};
        state_d = S_IDLE;
      end

      default: state_d = S_IDLE;
    endcase

    // Register write drops the built table
    if (cfg_we_i) begin
      vrange_d = cfg_wdata_i;
      built_d  = 1'b0;
    end
  end

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      item_q   <= '0;
      vrange_q <= VAL_W'(1023);
      loaded_q <= '0;
      built_q  <= 1'b0;
      open_q   <= 1'b0;
      k_q      <= '0;
      pv_q     <= 1'b0;
      pa_q     <= '0;
      run_q    <= '0;
      hi_q     <= '0;
      done_q   <= 1'b0;
      res_q    <= '{status: ST_OK, count: '0};
    end else begin
      state_q  <= state_d;
      item_q   <= item_d;
      vrange_q <= vrange_d;
      loaded_q <= loaded_d;
      built_q  <= built_d;
      open_q   <= open_d;
      k_q      <= k_d;
      pv_q     <= pv_d;
      pa_q     <= pa_d;
      run_q    <= run_d;
      hi_q     <= hi_d;
      done_q   <= done_d;
      res_q    <= res_d;
    end
  end

  // Count table, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rdata_q <= mem[ra];
    end
  end

  // A result strobe always leaves the block ready for the next word
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result strobe while busy");

  // Rejected words carry a zero count
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.status != ST_OK) |-> (result_o.count == '0))
    else $error("nonzero count with error status");

  // A query before the table is built is rejected in the next cycle
  a_not_built: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && cmd_i.action == ACT_QUERY && !built_q)
      |=> (done_o && result_o.status == ST_NOT_BUILT))
    else $error("query on unbuilt table not rejected");

  // The table is never marked built while a prefix pass runs
  a_pfx_unbuilt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PFX) |-> (!built_q && open_q))
    else $error("table built during prefix pass");

endmodule
